// ===== hw/rtl/gro_pkg.sv =====
package gro_pkg;

  // fixed field widths
  localparam int CMD_W    = 1;
  localparam int INDEX_W  = 8;
  localparam int DIM_W    = 5;
  localparam int OWNER_W  = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  // linear cell offsets inside the configured grid stay below 31 * 31
  localparam int LIN_W = 10;

  // parameter defaults
  localparam int DEF_MAX_COLUMNS = 16;
  localparam int DEF_MAX_ROWS    = 16;
  localparam int DEF_OWNER_BITS  = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;

  localparam logic [CFG_W-1:0] GRID_COLUMNS_RESET = 5'd16;
  localparam logic [CFG_W-1:0] GRID_ROWS_RESET    = 5'd16;

  // commands
  localparam logic [CMD_W-1:0] CMD_PLACE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

  // result codes
  localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

endpackage

// ===== hw/rtl/gro_cell_mem.sv =====
module gro_cell_mem
  import gro_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_COLUMNS * DEF_MAX_ROWS,
  parameter int ADDR_W = 8,
  parameter int DATA_W = DEF_OWNER_BITS
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/gro_div.sv =====
module gro_div
  import gro_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [INDEX_W-1:0] dividend,
  input  logic [DIM_W-1:0]   divisor,
  output logic               done,
  output logic [INDEX_W-1:0] quotient,
  output logic [DIM_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(INDEX_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DIM_W-1:0]   rem;
  logic [INDEX_W-1:0] quo;
  logic [DIM_W:0]     trial;
  logic               ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, quo[INDEX_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= ge ? DIM_W'(trial - {1'b0, divisor}) : trial[DIM_W-1:0];
        quo <= {quo[INDEX_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(INDEX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== hw/rtl/grid_rectangle_occupancy.sv =====
// Rectangle occupancy grid. Holds MAX_COLUMNS * MAX_ROWS owner cells in a
// single-port-write, registered-read memory; owner 0 marks an empty cell.
// After reset the block sweeps the memory to zero, one cell a cycle, with
// in_ready low; configuration writes are taken throughout. A place
// transaction splits top_left_index by the clamped column count in a
// bit-serial divider (8 steps), checks bounds, then walks the covered cells
// one per cycle through the memory read port (stopping early at the first
// occupied cell) and, if all were empty, walks them again through the write
// port. An out-of-bounds rectangle is rejected after the divider; zero width
// or height, or a zero owner, goes straight to the status. A remove
// transaction scans every cell of the store. A finished status waits until
// the output register is free. One transaction is in flight at a time; its
// status lands in an output register, so the next transaction may be
// accepted while the previous status is still waiting to be taken.
module grid_rectangle_occupancy
  import gro_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int OWNER_BITS  = DEF_OWNER_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [INDEX_W-1:0]   top_left_index,
  input  logic [DIM_W-1:0]     rect_width,
  input  logic [DIM_W-1:0]     rect_height,
  input  logic [OWNER_W-1:0]   owner_id,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status
);

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_CHECK_WAIT,
    S_FILL,
    S_SCAN,
    S_SCAN_WAIT,
    S_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [CFG_W-1:0] grid_columns;
  logic [CFG_W-1:0] grid_rows;
  logic [DIM_W-1:0] cols_eff;
  logic [DIM_W-1:0] rows_eff;

  // latched request
  logic [INDEX_W-1:0]    req_index;
  logic [DIM_W-1:0]      req_w;
  logic [DIM_W-1:0]      req_h;
  logic [OWNER_BITS-1:0] req_owner;
  logic [OWNER_BITS-1:0] owner_eff;
  logic [STATUS_W-1:0]   result;

  // rectangle walk
  logic [LIN_W-1:0] row_start;
  logic [DIM_W-1:0] col;
  logic [DIM_W-1:0] rows_left;
  logic [LIN_W-1:0] cell_lin;
  logic [ADDR_W-1:0] cell_addr;
  logic             walk_last;
  logic [LIN_W-1:0] row_start_next;
  logic [DIM_W-1:0] col_next;
  logic [DIM_W-1:0] rows_left_next;

  // whole-store sweep, shared by the clearing pass and removal
  logic [ADDR_W-1:0] scan_addr;
  logic [ADDR_W-1:0] pend_addr;
  logic              scan_last;
  logic              rd_pend;

  // divider
  logic               div_start;
  logic               div_done;
  logic [INDEX_W-1:0] div_quo;
  logic [DIM_W-1:0]   div_rem;
  logic               out_of_bounds;

  // memory ports
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [OWNER_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [OWNER_BITS-1:0] mem_rdata;

  // registers out of range are clamped when used
  always_comb begin
    if (grid_columns == '0) begin
      cols_eff = DIM_W'(1);
    end else if (32'(grid_columns) > MAX_COLUMNS) begin
      cols_eff = DIM_W'(MAX_COLUMNS);
    end else begin
      cols_eff = grid_columns;
    end
    if (grid_rows == '0) begin
      rows_eff = DIM_W'(1);
    end else if (32'(grid_rows) > MAX_ROWS) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows;
    end
  end

  // owner taken modulo 2^OWNER_BITS
  assign owner_eff = OWNER_BITS'(owner_id);

  assign in_ready = (state == S_IDLE);

  // the divider starts as a place transaction with a real area and a nonzero owner is accepted
  assign div_start = in_valid && in_ready && (owner_eff != '0) && (cmd == CMD_PLACE)
                     && (rect_width != '0) && (rect_height != '0);

  gro_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (top_left_index),
    .divisor   (cols_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // remainder is the left column, quotient the top row
  assign out_of_bounds = (div_quo >= INDEX_W'(rows_eff))
                      || ((6'(div_rem) + 6'(req_w)) > 6'(cols_eff))
                      || ((9'(div_quo) + 9'(req_h)) > 9'(rows_eff));

  // covered cells: x0 + y0 * cols is the top-left index, each row adds cols
  assign cell_lin  = row_start + LIN_W'(col);
  assign cell_addr = ADDR_W'(cell_lin);
  assign walk_last = ((6'(col) + 6'd1) == 6'(req_w)) && (rows_left == DIM_W'(1));

  always_comb begin
    if ((6'(col) + 6'd1) == 6'(req_w)) begin
      col_next       = '0;
      row_start_next = row_start + LIN_W'(cols_eff);
      rows_left_next = rows_left - 1'b1;
    end else begin
      col_next       = col + 1'b1;
      row_start_next = row_start;
      rows_left_next = rows_left;
    end
  end

  assign scan_last = (scan_addr == ADDR_W'(CELL_COUNT - 1));

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = '0;
    mem_raddr = cell_addr;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan_addr;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = req_owner;
      end
      S_SCAN, S_SCAN_WAIT: begin
        // clear the cell read last cycle if it holds the owner
        mem_we    = rd_pend && (mem_rdata == req_owner);
        mem_waddr = pend_addr;
        mem_raddr = scan_addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  gro_cell_mem #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W),
    .DATA_W (OWNER_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      grid_columns <= GRID_COLUMNS_RESET;
      grid_rows    <= GRID_ROWS_RESET;
      scan_addr    <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // configuration is taken in any state
      if (cfg_we) begin
        case (cfg_addr)
          REG_GRID_COLUMNS: grid_columns <= cfg_wdata;
          REG_GRID_ROWS:    grid_rows    <= cfg_wdata;
          default:          grid_rows    <= grid_rows;
        endcase
      end

      // a finishing transaction refills the output register itself
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (scan_last) begin
            scan_addr <= '0;
            state     <= S_IDLE;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end

        S_IDLE: begin
          rd_pend <= 1'b0;
          if (in_valid) begin
            req_index <= top_left_index;
            req_w     <= rect_width;
            req_h     <= rect_height;
            req_owner <= owner_eff;
            scan_addr <= '0;
            if (owner_eff == '0) begin
              result <= ST_IGNORED;
              state  <= S_FINISH;
            end else if (cmd == CMD_REMOVE) begin
              state <= S_SCAN;
            end else if ((rect_width == '0) || (rect_height == '0)) begin
              result <= ST_PLACED;
              state  <= S_FINISH;
            end else begin
              state <= S_DIV;
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            row_start <= LIN_W'(req_index);
            col       <= '0;
            rows_left <= req_h;
            if (out_of_bounds) begin
              result <= ST_REJECTED;
              state  <= S_FINISH;
            end else begin
              state <= S_CHECK;
            end
          end
        end

        // read the covered cells; each read is judged in the cycle after it
        S_CHECK: begin
          if (rd_pend && (mem_rdata != '0)) begin
            rd_pend <= 1'b0;
            result  <= ST_REJECTED;
            state   <= S_FINISH;
          end else begin
            rd_pend   <= 1'b1;
            col       <= col_next;
            row_start <= row_start_next;
            rows_left <= rows_left_next;
            if (walk_last) begin
              state <= S_CHECK_WAIT;
            end
          end
        end

        S_CHECK_WAIT: begin
          rd_pend   <= 1'b0;
          row_start <= LIN_W'(req_index);
          col       <= '0;
          rows_left <= req_h;
          if (mem_rdata != '0) begin
            result <= ST_REJECTED;
            state  <= S_FINISH;
          end else begin
            state <= S_FILL;
          end
        end

        S_FILL: begin
          col       <= col_next;
          row_start <= row_start_next;
          rows_left <= rows_left_next;
          if (walk_last) begin
            result <= ST_PLACED;
            state  <= S_FINISH;
          end
        end

        S_SCAN: begin
          rd_pend   <= 1'b1;
          pend_addr <= scan_addr;
          if (scan_last) begin
            scan_addr <= '0;
            state     <= S_SCAN_WAIT;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end

        S_SCAN_WAIT: begin
          rd_pend <= 1'b0;
          result  <= ST_REMOVED;
          state   <= S_FINISH;
        end

        // hold the result until the output register is free
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= result;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/grid_rectangle_occupancy_tb.sv =====
module grid_rectangle_occupancy_tb;
  import gro_pkg::*;

  // store size and owner mask at the block's default parameters
  localparam int CELLS = DEF_MAX_COLUMNS * DEF_MAX_ROWS;
  localparam logic [OWNER_W-1:0] OWNER_MASK = OWNER_W'((1 << DEF_OWNER_BITS) - 1);
  // quiet cycles after the last result, to catch a stray extra status
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    logic [CMD_W-1:0]   op;
    logic [INDEX_W-1:0] corner;
    logic [DIM_W-1:0]   span_x;
    logic [DIM_W-1:0]   span_y;
    logic [OWNER_W-1:0] owner;
  } request_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd;
  logic [INDEX_W-1:0]   top_left_index;
  logic [DIM_W-1:0]     rect_width;
  logic [DIM_W-1:0]     rect_height;
  logic [OWNER_W-1:0]   owner_id;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;

  // shadow copy of the occupancy store and of the two size registers
  logic [OWNER_W-1:0] cell_shadow [CELLS];
  logic [CFG_W-1:0]   cfg_columns = GRID_COLUMNS_RESET;
  logic [CFG_W-1:0]   cfg_rows    = GRID_ROWS_RESET;

  // statuses still owed by the block, oldest first
  logic [STATUS_W-1:0] pending_status_q [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int fail_count    = 0;
  int status_tally [4];

  grid_rectangle_occupancy dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .top_left_index(top_left_index),
    .rect_width    (rect_width),
    .rect_height   (rect_height),
    .owner_id      (owner_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run (reset sweep included)
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  // size registers are clamped into 1..max whenever they are used
  function automatic int usable_dim(input logic [CFG_W-1:0] v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // applies one request to the shadow grid and returns the status it earns
  function automatic logic [STATUS_W-1:0] predict_status(input request_t r);
    int cols;
    int rows;
    int x0;
    int y0;
    logic [OWNER_W-1:0] own;
    bit blocked;
    own = r.owner & OWNER_MASK;
    cols = usable_dim(cfg_columns, DEF_MAX_COLUMNS);
    rows = usable_dim(cfg_rows, DEF_MAX_ROWS);
    if (own == '0) return ST_IGNORED;
    if (r.op == CMD_REMOVE) begin
      // removal sweeps the whole store, not only the configured grid
      for (int i = 0; i < CELLS; i++)
        if (cell_shadow[i] == own) cell_shadow[i] = '0;
      return ST_REMOVED;
    end
    x0 = r.corner % cols;
    y0 = r.corner / cols;
    // an empty rectangle covers nothing and always counts as placed
    if (r.span_x == 0 || r.span_y == 0) return ST_PLACED;
    if (y0 >= rows || x0 + r.span_x > cols || y0 + r.span_y > rows) return ST_REJECTED;
    blocked = 1'b0;
    for (int y = y0; y < y0 + r.span_y; y++)
      for (int x = x0; x < x0 + r.span_x; x++)
        if (cell_shadow[(x + y * cols) % CELLS] != '0) blocked = 1'b1;
    if (blocked) return ST_REJECTED;
    for (int y = y0; y < y0 + r.span_y; y++)
      for (int x = x0; x < x0 + r.span_x; x++)
        cell_shadow[(x + y * cols) % CELLS] = own;
    return ST_PLACED;
  endfunction

  // random receiver back-pressure, rate set per phase
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // every status taken is compared with the oldest outstanding prediction
  always @(posedge clk) begin : status_check
    logic [STATUS_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pending_status_q.size() == 0) begin
        $error("status: expected nothing, got %0d", status);
        fail_count++;
      end else begin
        want = pending_status_q.pop_front();
        if (status !== want) begin
          $error("status: expected %0d, got %0d", want, status);
          fail_count++;
        end
      end
    end
  end

  // offers one transaction, with random idle cycles in front, and records
  // the predicted status once it is accepted; valid is left high so the
  // next transaction can follow back to back
  task automatic send_request(input request_t r);
    logic [STATUS_W-1:0] st;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    cmd            <= r.op;
    top_left_index <= r.corner;
    rect_width     <= r.span_x;
    rect_height    <= r.span_y;
    owner_id       <= r.owner;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    st = predict_status(r);
    status_tally[st]++;
    pending_status_q.push_back(st);
  endtask

  task automatic put_rect(input int corner, input int w, input int h, input int owner);
    request_t r;
    r = '{CMD_PLACE, INDEX_W'(corner), DIM_W'(w), DIM_W'(h), OWNER_W'(owner)};
    send_request(r);
  endtask

  task automatic drop_owner(input int owner);
    request_t r;
    r = '{CMD_REMOVE, INDEX_W'($urandom_range(0, 255)), DIM_W'($urandom_range(0, 31)),
          DIM_W'($urandom_range(0, 31)), OWNER_W'(owner)};
    send_request(r);
  endtask

  // sender holds off until the block has returned every owed status
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
  endtask

  // writes both size registers back to back; only called while idle
  task automatic set_grid(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_GRID_COLUMNS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_addr  <= REG_GRID_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cfg_columns = cols;
    cfg_rows    = rows;
  endtask

  // placement rules at the full 16 by 16 grid
  task automatic test_place_and_remove();
    set_grid(5'd16, 5'd16);
    put_rect(0, 16, 16, 255);      // whole grid in one transaction
    put_rect(255, 1, 1, 128);      // overlap on a full grid
    drop_owner(255);
    put_rect(255, 1, 1, 128);      // bottom-right cell
    put_rect(0, 0, 16, 5);         // zero width
    put_rect(255, 16, 0, 5);       // zero height
    put_rect(15, 2, 1, 5);         // crosses right edge
    put_rect(240, 1, 2, 5);        // crosses bottom edge
    put_rect(0, 31, 31, 5);        // oversize extents
    put_rect(0, 0, 0, 0);          // zero owner, place
    drop_owner(0);                 // zero owner, remove
    put_rect(0, 2, 2, 7);
    put_rect(34, 2, 2, 7);         // same owner in a second area
    put_rect(17, 1, 1, 9);         // hits owner 7
    drop_owner(7);
    put_rect(17, 1, 1, 9);
    drop_owner(200);               // owner that holds nothing
    drop_owner(128);
    drop_owner(9);
  endtask

  // register clamping and the row-beyond-grid rejection
  task automatic test_grid_limits();
    set_grid(5'd0, 5'd0);          // clamps to a single cell
    put_rect(0, 1, 1, 3);
    put_rect(1, 1, 1, 4);          // top-left row past the last row
    put_rect(0, 1, 1, 4);
    drop_owner(3);
    set_grid(5'd31, 5'd31);        // clamps to 16 by 16
    put_rect(240, 16, 1, 4);
    drop_owner(4);
  endtask

  // cells survive a resize and are read through the new column count
  task automatic test_resize_keeps_cells();
    set_grid(5'd16, 5'd16);
    put_rect(200, 1, 1, 11);
    set_grid(5'd4, 5'd4);
    drop_owner(11);                // cell lies outside the 4 by 4 grid
    put_rect(5, 2, 2, 9);
    put_rect(15, 1, 1, 10);
    set_grid(5'd16, 5'd16);
    put_rect(5, 1, 1, 3);          // stored cell 5 still owned
    put_rect(200, 1, 1, 12);       // freed by the earlier removal
    put_rect(7, 1, 1, 3);
  endtask

  // extents: mostly small, some up to the grid size, a few past the grid size
  function automatic logic [DIM_W-1:0] random_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return DIM_W'($urandom_range(1, 3));
    if (pick < 90) return DIM_W'($urandom_range(0, 16));
    if (pick < 95) return '0;
    return DIM_W'($urandom_range(17, 31));
  endfunction

  // random traffic at one grid size and one idling mix; owners come mostly
  // from a small pool so removals find cells and placements collide
  task automatic test_random_traffic(input int count, input logic [CFG_W-1:0] cols,
                                     input logic [CFG_W-1:0] rows, input int idle,
                                     input int stall);
    request_t r;
    int pick;
    int area;
    set_grid(cols, rows);
    send_idle_pct = idle;
    stall_pct     = stall;
    area = usable_dim(cols, DEF_MAX_COLUMNS) * usable_dim(rows, DEF_MAX_ROWS);
    for (int n = 0; n < count; n++) begin
      r.op = ($urandom_range(0, 99) < 12) ? CMD_REMOVE : CMD_PLACE;
      pick = $urandom_range(0, 99);
      if (pick < 5) r.owner = '0;
      else if (pick < 15) r.owner = OWNER_W'($urandom_range(0, 255));
      else r.owner = OWNER_W'($urandom_range(1, 12));
      if ($urandom_range(0, 99) < 15) r.corner = INDEX_W'($urandom_range(0, 255));
      else r.corner = INDEX_W'($urandom_range(0, area - 1));
      r.span_x = random_span();
      r.span_y = random_span();
      send_request(r);
      // now and then let the block run dry before carrying on
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = REG_GRID_COLUMNS;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    cmd       = CMD_PLACE;
    top_left_index = '0;
    rect_width     = '0;
    rect_height    = '0;
    owner_id       = '0;
    foreach (cell_shadow[i]) cell_shadow[i] = '0;
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_place_and_remove();
    test_grid_limits();
    test_resize_keeps_cells();
    // four idling mixes, each at two grid shapes
    test_random_traffic(250, 5'd16, 5'd16, 0, 0);
    test_random_traffic(250, 5'd5, 5'd9, 0, 0);
    test_random_traffic(250, 5'd16, 5'd3, 45, 0);
    test_random_traffic(250, 5'd7, 5'd16, 45, 0);
    test_random_traffic(250, 5'd1, 5'd16, 0, 45);
    test_random_traffic(250, 5'd12, 5'd12, 0, 45);
    test_random_traffic(250, 5'd16, 5'd1, 29, 29);
    test_random_traffic(250, 5'd16, 5'd16, 29, 29);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d requests: %0d placed, %0d rejected, %0d removed, %0d ignored",
             status_tally[ST_PLACED] + status_tally[ST_REJECTED] +
             status_tally[ST_REMOVED] + status_tally[ST_IGNORED],
             status_tally[ST_PLACED], status_tally[ST_REJECTED],
             status_tally[ST_REMOVED], status_tally[ST_IGNORED]);
    $display("grid shapes from 1x1 to 16x16 incl. clamped sizes, under four idle/stall mixes");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
